[hdl/pcrv_pkg.sv]
// ----------------------------------------------------------------------------
// pcrv_pkg
// Shared widths, constants and controller/datapath interface types for the
// per-channel running variance block.
// ----------------------------------------------------------------------------
package pcrv_pkg;

  localparam int SLOTS        = 16;
  localparam int CHANNELS_DEF = 16;

  localparam int CH_W   = 4;
  localparam int E_W    = 24;
  localparam int V_W    = 48;
  localparam int F_W    = 16;
  localparam int CNT_W  = F_W + 1;
  localparam int STEP_W = 6;

  localparam logic [STEP_W-1:0] DIV_STEPS_ACC = STEP_W'(E_W);
  localparam logic [STEP_W-1:0] DIV_STEPS_FIN = STEP_W'(V_W);

  localparam logic ACT_ACCUM  = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef struct packed {
    logic load;
    logic acc_rd;
    logic fin_rd;
    logic div_go;
    logic div_fin;
    logic upd_mean;
    logic mul;
    logic acc_wr;
    logic emit;
    logic k_clr;
    logic k_inc;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic k_last;
  } sts_t;

endpackage

[hdl/per_channel_running_variance.sv]
// ----------------------------------------------------------------------------
// per_channel_running_variance
// Welford running mean and M2 per channel over frames of Q8.16 energies.
// Requests are accepted when start is high and busy is low. An accumulate
// request keeps busy high through one read, a 24-step quotient on the
// shared radix-2 divider (one bit per cycle), then mean update, multiply and
// write-back. A finish request emits one result per active channel, each one
// after a 48-step divide of M2 by frames minus one on the same divider, so
// the block stays busy until all min(CHANNELS, 16) results are out. Results
// appear for a single cycle with out_strobe and cannot be held off; the last
// one carries out_last, and all state is cleared by then.
// ----------------------------------------------------------------------------
module per_channel_running_variance #(
  parameter int CHANNELS = pcrv_pkg::CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_action,
  input  logic [pcrv_pkg::CH_W-1:0]  in_channel,
  input  logic [pcrv_pkg::E_W-1:0]   in_energy,
  input  logic                       in_frame_end,
  output logic                       out_strobe,
  output logic [pcrv_pkg::CH_W-1:0]  out_channel,
  output logic [pcrv_pkg::E_W-1:0]   out_mean,
  output logic [pcrv_pkg::V_W-1:0]   out_variance,
  output logic                       out_variance_valid,
  output logic                       out_last
);
  import pcrv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pcrv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .busy      (busy),
    .cmd       (cmd),
    .sts       (sts)
  );

  pcrv_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_channel         (in_channel),
    .in_energy          (in_energy),
    .in_frame_end       (in_frame_end),
    .out_strobe         (out_strobe),
    .out_channel        (out_channel),
    .out_mean           (out_mean),
    .out_variance       (out_variance),
    .out_variance_valid (out_variance_valid),
    .out_last           (out_last)
  );

endmodule

[hdl/pcrv_div.sv]
// ----------------------------------------------------------------------------
// pcrv_div
// Restoring radix-2 divider, one quotient bit per cycle. The dividend shifts
// out at the top while quotient bits shift in at the bottom; after N steps the
// low N bits hold the quotient of the top N dividend bits.
// ----------------------------------------------------------------------------
module pcrv_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [pcrv_pkg::V_W-1:0]    dividend,
  input  logic [pcrv_pkg::CNT_W-1:0]  divisor,
  input  logic [pcrv_pkg::STEP_W-1:0] steps,
  output logic                        done,
  output logic [pcrv_pkg::V_W-1:0]    quo
);
  import pcrv_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [V_W-1:0]    quo_r;

  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W:0]    rem_dif;

  assign rem_sh  = {rem_r, quo_r[V_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_dif = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r <= {quo_r[V_W-2:0], ge};
    end
  end

  assign done = done_r && !busy_r;
  assign quo  = quo_r;

  a_go_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> !done_r && busy_r)
    else $error("divider did not start");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !go && cnt_r == STEP_W'(1) |=> done && !busy_r)
    else $error("divider did not finish after its last step");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still iterating");

endmodule

[hdl/pcrv_dp.sv]
// ----------------------------------------------------------------------------
// pcrv_dp
// Datapath: per-channel mean and M2 stores with valid bits, frame counter,
// Welford update arithmetic, shared divider and result registers.
// ----------------------------------------------------------------------------
module pcrv_dp #(
  parameter int CHANNELS = pcrv_pkg::CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pcrv_pkg::cmd_t             cmd,
  output pcrv_pkg::sts_t             sts,
  input  logic [pcrv_pkg::CH_W-1:0]  in_channel,
  input  logic [pcrv_pkg::E_W-1:0]   in_energy,
  input  logic                       in_frame_end,
  output logic                       out_strobe,
  output logic [pcrv_pkg::CH_W-1:0]  out_channel,
  output logic [pcrv_pkg::E_W-1:0]   out_mean,
  output logic [pcrv_pkg::V_W-1:0]   out_variance,
  output logic                       out_variance_valid,
  output logic                       out_last
);
  import pcrv_pkg::*;

  localparam int ACTIVE = (CHANNELS < SLOTS) ? CHANNELS : SLOTS;
  localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam logic [CH_W:0]    ACT_L  = (CH_W + 1)'(ACTIVE);
  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(ACTIVE - 1);

  logic [E_W-1:0] mean_mem [ACTIVE];
  logic [V_W-1:0] spr_mem  [ACTIVE];
  logic [ACTIVE-1:0] valid_r;
  logic [F_W-1:0]    frames_r;
  logic [IDX_W-1:0]  k_r;

  logic [CH_W-1:0]    ch_r;
  logic [E_W-1:0]     x_r;
  logic               fend_r;
  logic [E_W-1:0]     mean_old_r;
  logic [V_W-1:0]     spr_r;
  logic [E_W-1:0]     newm_r;
  logic signed [2*E_W+1:0] prod_r;

  logic               strobe_r;
  logic [CH_W-1:0]    och_r;
  logic [E_W-1:0]     omean_r;
  logic [V_W-1:0]     ovar_r;
  logic               ovv_r;
  logic               olast_r;

  logic               ch_in;
  logic               rd_ok;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_hit;
  logic               var_ok;
  logic signed [E_W:0] diff;

  logic [V_W-1:0]     div_dvd;
  logic [CNT_W-1:0]   div_dvs;
  logic [STEP_W-1:0]  div_steps;
  logic               div_done;
  logic [V_W-1:0]     div_quo;
  logic [E_W:0]       dmag;

  logic [E_W:0]       mean_sum;
  logic signed [E_W:0] fac;
  logic signed [2*E_W+1:0] prod_nxt;
  logic               pneg;
  logic [2*E_W+1:0]   pmag;
  logic [2*E_W-15:0]  tmag;
  logic signed [V_W+2:0] m2_sum;
  logic [V_W-1:0]     m2_sat;

  assign ch_in  = {1'b0, ch_r} < ACT_L;
  assign rd_ok  = cmd.fin_rd || ch_in;
  assign rd_idx = cmd.fin_rd ? k_r : ch_r[IDX_W-1:0];
  assign rd_hit = rd_ok && valid_r[rd_idx];
  assign var_ok = frames_r >= F_W'(2);
  assign diff   = $signed({1'b0, x_r}) - $signed({1'b0, mean_old_r});

  assign dmag = diff[E_W] ? (E_W + 1)'(-diff) : (E_W + 1)'(diff);

  always_comb begin
    if (cmd.div_fin) begin
      div_dvd   = spr_r;
      div_dvs   = {1'b0, frames_r - F_W'(1)};
      div_steps = DIV_STEPS_FIN;
    end else begin
      div_dvd   = {dmag[E_W-1:0], {(V_W - E_W){1'b0}}};
      div_dvs   = {1'b0, frames_r} + CNT_W'(1);
      div_steps = DIV_STEPS_ACC;
    end
  end

  pcrv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .done     (div_done),
    .quo      (div_quo)
  );

  assign mean_sum = diff[E_W] ? ({1'b0, mean_old_r} - {1'b0, div_quo[E_W-1:0]})
                              : ({1'b0, mean_old_r} + {1'b0, div_quo[E_W-1:0]});
  assign fac      = $signed({1'b0, x_r}) - $signed({1'b0, newm_r});
  assign prod_nxt = (2*E_W + 2)'(diff) * (2*E_W + 2)'(fac);

  assign pneg   = prod_r[2*E_W+1];
  assign pmag   = pneg ? (2*E_W + 2)'(-prod_r) : (2*E_W + 2)'(prod_r);
  assign tmag   = pmag[2*E_W+1:16];
  assign m2_sum = pneg ? ($signed({3'b0, spr_r}) - $signed({17'b0, tmag}))
                       : ($signed({3'b0, spr_r}) + $signed({17'b0, tmag}));

  always_comb begin
    if (m2_sum[V_W+2]) begin
      m2_sat = '0;
    end else if (m2_sum[V_W+1:V_W] != 2'b00) begin
      m2_sat = '1;
    end else begin
      m2_sat = m2_sum[V_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      frames_r <= '0;
      k_r      <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
      if (cmd.k_clr) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.clear) begin
        valid_r  <= '0;
        frames_r <= '0;
      end else if (cmd.acc_wr) begin
        if (ch_in) begin
          valid_r[ch_r[IDX_W-1:0]] <= 1'b1;
        end
        if (fend_r && frames_r != '1) begin
          frames_r <= frames_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_wr && ch_in) begin
      mean_mem[ch_r[IDX_W-1:0]] <= newm_r;
      spr_mem[ch_r[IDX_W-1:0]]  <= m2_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r   <= in_channel;
      x_r    <= in_energy;
      fend_r <= in_frame_end;
    end
    if (cmd.acc_rd || cmd.fin_rd) begin
      mean_old_r <= rd_hit ? mean_mem[rd_idx] : '0;
      spr_r      <= rd_hit ? spr_mem[rd_idx]  : '0;
    end
    if (cmd.upd_mean) begin
      newm_r <= mean_sum[E_W-1:0];
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.emit) begin
      och_r   <= CH_W'(k_r);
      omean_r <= mean_old_r;
      ovar_r  <= var_ok ? div_quo : '0;
      ovv_r   <= var_ok;
      olast_r <= k_r == K_LAST;
    end
  end

  assign sts.div_done = div_done;
  assign sts.k_last   = k_r == K_LAST;

  assign out_strobe         = strobe_r;
  assign out_channel        = och_r;
  assign out_mean           = omean_r;
  assign out_variance       = ovar_r;
  assign out_variance_valid = ovv_r;
  assign out_last           = olast_r;

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> frames_r == '0 && valid_r == '0)
    else $error("state not cleared after finish");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && !ovv_r |-> ovar_r == '0)
    else $error("variance nonzero while flagged invalid");

  a_last_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && olast_r |-> frames_r == '0)
    else $error("final result without cleared frame count");

  a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> div_done)
    else $error("result taken before division completed");

endmodule

[hdl/pcrv_ctrl.sv]
// ----------------------------------------------------------------------------
// pcrv_ctrl
// Controller: sequences the accumulate update and the per-channel finish
// sweep, issuing datapath commands and reporting busy.
// ----------------------------------------------------------------------------
module pcrv_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_action,
  output logic           busy,
  output pcrv_pkg::cmd_t cmd,
  input  pcrv_pkg::sts_t sts
);
  import pcrv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_RD,
    S_ACC_DIV,
    S_ACC_WAIT,
    S_ACC_MEAN,
    S_ACC_MUL,
    S_ACC_WR,
    S_FIN_RD,
    S_FIN_DIV,
    S_FIN_WAIT,
    S_FIN_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cmd.k_clr = 1'b1;
          state_nxt = (in_action == ACT_FINISH) ? S_FIN_RD : S_ACC_RD;
        end
      end
      S_ACC_RD: begin
        cmd.acc_rd = 1'b1;
        state_nxt  = S_ACC_DIV;
      end
      S_ACC_DIV: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_ACC_WAIT;
      end
      S_ACC_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_ACC_MEAN;
        end
      end
      S_ACC_MEAN: begin
        cmd.upd_mean = 1'b1;
        state_nxt    = S_ACC_MUL;
      end
      S_ACC_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_FIN_RD: begin
        cmd.fin_rd = 1'b1;
        state_nxt  = S_FIN_DIV;
      end
      S_FIN_DIV: begin
        cmd.div_go  = 1'b1;
        cmd.div_fin = 1'b1;
        state_nxt   = S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        cmd.div_fin = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_FIN_OUT;
        end
      end
      S_FIN_OUT: begin
        cmd.div_fin = 1'b1;
        cmd.emit    = 1'b1;
        if (sts.k_last) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_FIN_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != S_IDLE;
    end
  end

  assign busy = busy_r;

  a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != S_IDLE))
    else $error("busy out of step with controller state");

  a_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r |=> busy_r)
    else $error("accepted request did not start work");

  a_out_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN_OUT |=> state_r == S_IDLE || state_r == S_FIN_RD)
    else $error("finish sweep left its sequence");

  a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC_WAIT || state_r == S_FIN_WAIT) && !sts.div_done |=> $stable(state_r))
    else $error("left divide wait before quotient ready");

endmodule
